@@ rtl/core/qgm_pkg.sv @@
// Package: constants, types and Gray level tables for the QAM Gray mapper.
package qgm_pkg;

	localparam int CFG_W  = 4;
	localparam int COLL_W = 8;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 4;
	localparam int LVL_W  = 15;
	localparam int HALF_W = 3;

	localparam logic [CFG_W-1:0] MODE_BPSK   = 4'd1;
	localparam logic [CFG_W-1:0] MODE_QPSK   = 4'd2;
	localparam logic [CFG_W-1:0] MODE_QAM16  = 4'd4;
	localparam logic [CFG_W-1:0] MODE_QAM64  = 4'd6;
	localparam logic [CFG_W-1:0] MODE_QAM256 = 4'd8;

	localparam logic signed [LVL_W-1:0] BPSK_LVL = 15'sd10000;

	typedef struct packed {
		logic              err;
		logic [CFG_W-1:0]  mode;
		logic [COLL_W-1:0] sym;
	} sym_t;

	typedef struct packed {
		logic                    err;
		logic signed [LVL_W-1:0] q_val;
		logic signed [LVL_W-1:0] i_val;
	} point_t;

	function automatic logic mode_ok(input logic [CFG_W-1:0] m);
		return (m == MODE_BPSK) || (m == MODE_QPSK) || (m == MODE_QAM16) ||
			(m == MODE_QAM64) || (m == MODE_QAM256);
	endfunction

	function automatic logic signed [LVL_W-1:0] lvl_qpsk(input logic idx);
		return idx ? 15'sd7071 : -15'sd7071;
	endfunction

	function automatic logic signed [LVL_W-1:0] lvl_16(input logic [1:0] idx);
		logic signed [LVL_W-1:0] v;
		case (idx)
			2'd0: v = -15'sd9486;
			2'd1: v = -15'sd3162;
			2'd2: v = 15'sd9486;
			default: v = 15'sd3162;
		endcase
		return v;
	endfunction

	function automatic logic signed [LVL_W-1:0] lvl_64(input logic [2:0] idx);
		logic signed [LVL_W-1:0] v;
		case (idx)
			3'd0: v = -15'sd10801;
			3'd1: v = -15'sd7715;
			3'd2: v = -15'sd1543;
			3'd3: v = -15'sd4629;
			3'd4: v = 15'sd10801;
			3'd5: v = 15'sd7715;
			3'd6: v = 15'sd1543;
			default: v = 15'sd4629;
		endcase
		return v;
	endfunction

	function automatic logic signed [LVL_W-1:0] lvl_256(input logic [IDX_W-1:0] idx);
		logic signed [LVL_W-1:0] v;
		case (idx)
			4'd0:  v = -15'sd11504;
			4'd1:  v = -15'sd9970;
			4'd2:  v = -15'sd6902;
			4'd3:  v = -15'sd8436;
			4'd4:  v = -15'sd766;
			4'd5:  v = -15'sd2300;
			4'd6:  v = -15'sd5368;
			4'd7:  v = -15'sd3834;
			4'd8:  v = 15'sd11504;
			4'd9:  v = 15'sd9970;
			4'd10: v = 15'sd6902;
			4'd11: v = 15'sd8436;
			4'd12: v = 15'sd766;
			4'd13: v = 15'sd2300;
			4'd14: v = 15'sd5368;
			default: v = 15'sd3834;
		endcase
		return v;
	endfunction

	function automatic logic signed [LVL_W-1:0] level(input logic [CFG_W-1:0] m,
		input logic [IDX_W-1:0] idx);
		logic signed [LVL_W-1:0] v;
		case (m)
			MODE_QPSK:  v = lvl_qpsk(idx[0]);
			MODE_QAM16: v = lvl_16(idx[1:0]);
			MODE_QAM64: v = lvl_64(idx[2:0]);
			default:    v = lvl_256(idx);
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/qgm_point_map.sv @@
// Symbol index to constellation point lookup.
module qgm_point_map
	import qgm_pkg::*;
(
	input  sym_t   sym_in,
	output point_t pt
);

	logic [HALF_W-1:0] half;
	logic [COLL_W-1:0] i_sh;
	logic [COLL_W-1:0] q_mask;
	logic [IDX_W-1:0]  i_idx;
	logic [IDX_W-1:0]  q_idx;

	assign half   = sym_in.mode[HALF_W:1];
	assign i_sh   = sym_in.sym >> half;
	assign q_mask = (COLL_W'(1) << half) - COLL_W'(1);
	assign i_idx  = i_sh[IDX_W-1:0];
	assign q_idx  = IDX_W'(sym_in.sym & q_mask);

	always_comb begin
		pt.err   = sym_in.err;
		pt.i_val = '0;
		pt.q_val = '0;
		if (!sym_in.err) begin
			if (sym_in.mode == MODE_BPSK) begin
				pt.i_val = sym_in.sym[0] ? BPSK_LVL : -BPSK_LVL;
			end else begin
				pt.i_val = level(sym_in.mode, i_idx);
				pt.q_val = level(sym_in.mode, q_idx);
			end
		end
	end

endmodule

@@ rtl/core/qam_gray_mapper_unit.sv @@
// Top level: Gray-coded BPSK/QPSK/QAM constellation mapper with stream ports.
//
// Input stream: one coded bit per transaction in s_axis_tdata[0], s_axis_tlast
// marks the last bit of a block. Bits are collected MSB first until
// bits_per_symbol (cfg_wdata, written with cfg_we) are in; that transaction
// then produces one point on the output stream: I in tdata[14:0], Q in
// tdata[29:15], tuser set for an unsupported mode (then every input bit gives
// a zero point with tuser set). A tlast on a partial symbol drops it; a
// register write also drops it.
// Path: the transaction carrying the symbol's last bit loads the symbol
// register; the table lookup then fills the output register, which drives
// m_axis_tvalid and holds the point until m_axis_tready takes it.
// Throughput: one bit per clock while s_axis_tready is high; the two-entry
// pipeline keeps taking bits while the output holds a point, until the first
// stage also holds one.
// Stall: when m_axis_tready is low the output register holds, the first
// stage fills, and s_axis_tready drops once both stages hold a point.
// Reset: bits_per_symbol returns to 1 (BPSK), the collector and both stages
// are emptied.
module qam_gray_mapper_unit
	import qgm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [0] coded_bit, [7:1] zero
	input  logic             s_axis_tlast,  // end_of_block
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [14:0] i_value, [29:15] q_value, [31:30] zero
	output logic             m_axis_tuser   // [0] mode_error
);

	logic [CFG_W-1:0]  bps_q;
	logic [COLL_W-1:0] coll_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              valid_s1;
	sym_t              sym_s1;
	logic              valid_s2;
	point_t            pt_s2;

	logic              accept_in;
	logic              ready_s2;
	logic              ok;
	logic [COLL_W-1:0] coll_nx;
	logic [CNT_W-1:0]  cnt_nx;
	logic              complete;
	logic [COLL_W:0]   mask9;
	logic              produce;
	point_t            pt_nx;

	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || ready_s2;
	assign accept_in     = s_axis_tvalid && s_axis_tready;

	assign ok       = mode_ok(bps_q);
	assign coll_nx  = {coll_q[COLL_W-2:0], s_axis_tdata[0]};
	assign cnt_nx   = cnt_q + CNT_W'(1);
	assign complete = cnt_nx >= bps_q;
	assign mask9    = ((COLL_W+1)'(1) << bps_q) - (COLL_W+1)'(1);
	assign produce  = !ok || complete;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q  <= MODE_BPSK;
			coll_q <= '0;
			cnt_q  <= '0;
		end else if (cfg_we) begin
			bps_q  <= cfg_wdata;
			coll_q <= '0;
			cnt_q  <= '0;
		end else if (accept_in) begin
			if (produce || s_axis_tlast) begin
				coll_q <= '0;
				cnt_q  <= '0;
			end else begin
				coll_q <= coll_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= produce;
		end else if (ready_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in && produce) begin
			sym_s1.err  <= !ok;
			sym_s1.mode <= bps_q;
			sym_s1.sym  <= coll_nx & mask9[COLL_W-1:0];
		end
	end

	qgm_point_map u_map (
		.sym_in (sym_s1),
		.pt     (pt_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			pt_s2 <= pt_nx;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, pt_s2.q_val, pt_s2.i_val};
	assign m_axis_tuser  = pt_s2.err;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
		else $error("error point carries nonzero data");

	a_i_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[LVL_W-1:0] != '0)
		else $error("valid point with zero I level");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> cnt_q == '0 && coll_q == '0)
		else $error("register write did not drop partial symbol");

endmodule
